[src/apc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants of the average predictor codec
// Sizes of the line store and position counter, config register indexes and
// the control structs passed between the blocks.
// ----------------------------------------------------------------------------
package apc_pkg;

	// Longest block row held in the line store
	localparam int MAX_WIDTH = 1024;
	// Column index width and column count width (count holds MAX_WIDTH itself)
	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CNT_W = COL_W + 1;

	localparam int DATA_W = 32;
	localparam int BW_W   = 11;
	localparam int IDX_W  = 2;

	// Config register indexes
	localparam logic [IDX_W-1:0] REG_MODE        = 2'd0;
	localparam logic [IDX_W-1:0] REG_BLOCK_WIDTH = 2'd1;
	localparam logic [IDX_W-1:0] REG_HAS_LEFT    = 2'd2;
	localparam logic [IDX_W-1:0] REG_HAS_ABOVE   = 2'd3;

	// Mode codes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [CNT_W-1:0] eff_width;
		logic             has_left;
		logic             has_above;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic             first_row;
	} pos_t;

endpackage

[src/apc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_cfg_regs: configuration registers
// Holds mode, block width and border flags; clamps the width to 1..MAX_WIDTH.
// ----------------------------------------------------------------------------
module apc_cfg_regs
	import apc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [BW_W-1:0]   cfg_data,
	output cfg_t              cfg
);

	logic            mode_q;
	logic [BW_W-1:0] block_width_q;
	logic            has_left_q;
	logic            has_above_q;
	logic [31:0]     bw_ext;
	logic [31:0]     eff_ext;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_ENCODE;
			block_width_q <= BW_W'(8);
			has_left_q    <= 1'b0;
			has_above_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        mode_q        <= cfg_data[0];
				REG_BLOCK_WIDTH: block_width_q <= cfg_data;
				REG_HAS_LEFT:    has_left_q    <= cfg_data[0];
				REG_HAS_ABOVE:   has_above_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the width: zero acts as one, anything past the store acts as full
	always_comb begin
		bw_ext = {{(32-BW_W){1'b0}}, block_width_q};
		if (bw_ext == 32'd0)
			eff_ext = 32'd1;
		else if (bw_ext > 32'(MAX_WIDTH))
			eff_ext = 32'(MAX_WIDTH);
		else
			eff_ext = bw_ext;
	end

	assign cfg.mode      = mode_q;
	assign cfg.eff_width = eff_ext[CNT_W-1:0];
	assign cfg.has_left  = has_left_q;
	assign cfg.has_above = has_above_q;

endmodule

[src/apc_position.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_position: raster position tracker
// Gives the column and first-row flag of the beat being taken and advances
// them once per accepted beat.
// ----------------------------------------------------------------------------
module apc_position
	import apc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             block_start,
	input  logic [CNT_W-1:0] eff_width,
	output pos_t             pos
);

	logic [COL_W-1:0] col_q;
	logic             first_q;
	logic [CNT_W-1:0] col_inc;

	// Restart at column zero of the first row on a block start
	always_comb begin
		if (block_start) begin
			pos.column    = '0;
			pos.first_row = 1'b1;
		end else begin
			pos.column    = col_q;
			pos.first_row = first_q;
		end
		col_inc = {1'b0, pos.column} + CNT_W'(1);
	end

	// Advance, wrapping to the next row at the end of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (advance) begin
			if (col_inc >= eff_width) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q   <= col_inc[COL_W-1:0];
				first_q <= pos.first_row;
			end
		end
	end

endmodule

[src/apc_line_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_line_ram: line store of the previous block row
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module apc_line_ram
	import apc_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [COL_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [COL_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [MAX_WIDTH];

	// Write the pixel of the finished beat
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Read the above neighbor of the beat being taken
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

[src/average_pixel_predictor_codec.sv]
`timescale 1ns / 1ps
// Average predictor codec: value = sample -/+ (left + above) / 2.
// An accepted input beat reads the line store into stage 1, then is predicted and
// registered as the output beat. Throughput: 1 beat per cycle while the output
// is not stalled, set by the single read and single write port of the line store,
// with same-column forwarding. Reset clears config to defaults, position to column
// zero of the first row and empties the pipeline; the line store is not cleared.
// ----------------------------------------------------------------------------
// average_pixel_predictor_codec: top level
// Tracks position, reads the above neighbor from the line store, forms the
// prediction, encodes or decodes and writes the pixel back.
// ----------------------------------------------------------------------------
module average_pixel_predictor_codec
	import apc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [BW_W-1:0]          cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] sample,
	input  logic signed [DATA_W-1:0] left_border,
	input  logic signed [DATA_W-1:0] top_border,
	input  logic                     block_start,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] value
);

	cfg_t cfg;
	pos_t pos;

	logic in_acc;
	logic s1_adv;

	logic                     s1_valid_q;
	logic signed [DATA_W-1:0] sample_s1;
	logic signed [DATA_W-1:0] left_border_s1;
	logic signed [DATA_W-1:0] top_border_s1;
	logic [COL_W-1:0]         col_s1;
	logic                     first_s1;
	logic                     byp_s1;
	logic signed [DATA_W-1:0] byp_data_s1;

	logic signed [DATA_W-1:0] left_q;
	logic [DATA_W-1:0]        rd_data;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] value_q;

	logic signed [DATA_W-1:0] left_nb;
	logic signed [DATA_W-1:0] above_nb;
	logic signed [DATA_W:0]   sum;
	logic signed [DATA_W:0]   sum_adj;
	logic signed [DATA_W-1:0] pred;
	logic signed [DATA_W-1:0] pixel;
	logic signed [DATA_W-1:0] result;

	apc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apc_position u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (in_acc),
		.block_start (block_start),
		.eff_width   (cfg.eff_width),
		.pos         (pos)
	);

	apc_line_ram u_ram (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (pixel),
		.rd_en   (in_acc),
		.rd_addr (pos.column),
		.rd_data (rd_data)
	);

	// Handshake: stage 1 moves on when the output register is free or drains
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	// Pick neighbors; forward the pixel being written when columns collide
	always_comb begin
		if (col_s1 == '0)
			left_nb = cfg.has_left ? left_border_s1 : '0;
		else
			left_nb = left_q;
		if (first_s1)
			above_nb = cfg.has_above ? top_border_s1 : '0;
		else if (byp_s1)
			above_nb = byp_data_s1;
		else
			above_nb = $signed(rd_data);
		// Halve toward zero: bias negative sums by one before the shift
		sum     = {left_nb[DATA_W-1], left_nb} + {above_nb[DATA_W-1], above_nb};
		sum_adj = sum + $signed({{DATA_W{1'b0}}, sum[DATA_W]});
		pred    = sum_adj[DATA_W:1];
		if (cfg.mode == MODE_DECODE) begin
			pixel  = sample_s1 + pred;
			result = pixel;
		end else begin
			pixel  = sample_s1;
			result = sample_s1 - pred;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	// Stage 1 payload; note a same-column write landing at this edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1      <= sample;
			left_border_s1 <= left_border;
			top_border_s1  <= top_border;
			col_s1         <= pos.column;
			first_s1       <= pos.first_row;
			byp_s1         <= s1_adv && (col_s1 == pos.column);
			byp_data_s1    <= pixel;
		end
	end

	// Keep the pixel as the next left neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			left_q <= '0;
		else if (s1_adv)
			left_q <= pixel;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			value_q <= result;
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// An accepted beat always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid_q)
		else $error("accepted beat did not reach stage 1");

	// A blocked stage 1 beat keeps its column
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(col_s1)))
		else $error("stage 1 beat changed while blocked");

	// A stalled output beat keeps its value
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(value_q)))
		else $error("output beat changed while stalled");

	// The line store is written only when a result enters the output register
	a_write_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("line store write without output beat");

endmodule

[tb/apc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_checker: value checker for the average predictor codec
// Mirrors the config port, tracks block position, left pixel and previous row,
// predicts each output value from the accepted input beats and compares the
// output beats against the oldest prediction in order.
// ----------------------------------------------------------------------------
module apc_checker
	import apc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [BW_W-1:0]          cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [DATA_W-1:0] sample,
	input  logic signed [DATA_W-1:0] left_border,
	input  logic signed [DATA_W-1:0] top_border,
	input  logic                     block_start,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] value,
	output int                       mismatches,
	output int                       values_due
);

	// Neighbor average divides by two, truncating toward zero
	localparam int AVG_DIV = 2;

	// Mirrored config registers
	logic             cfg_mode;
	logic [BW_W-1:0]  cfg_width;
	logic             cfg_has_left;
	logic             cfg_has_above;

	// Mirrored position and pixel history
	int               col;
	logic             top_row;
	logic [DATA_W-1:0] left_pix;
	logic [DATA_W-1:0] row_mem [0:MAX_WIDTH-1];

	logic signed [DATA_W-1:0] expected_values [$];

	// Average of two neighbors, formed one bit wider so the sum cannot wrap
	function automatic logic [DATA_W-1:0] avg_prediction(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic signed [DATA_W:0] total;
		logic signed [DATA_W:0] quot;
		total = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
		quot  = total / AVG_DIV;
		return quot[DATA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic signed [DATA_W-1:0] exp_val;
		logic [DATA_W-1:0]        nb_left;
		logic [DATA_W-1:0]        nb_above;
		logic [DATA_W-1:0]        pred;
		logic [DATA_W-1:0]        pixel;
		logic [DATA_W-1:0]        result;
		int                       eff_w;
		if (!arst_n) begin
			cfg_mode      = MODE_ENCODE;
			cfg_width     = BW_W'(8);
			cfg_has_left  = 1'b0;
			cfg_has_above = 1'b0;
			col           = 0;
			top_row       = 1'b1;
			left_pix      = '0;
			expected_values.delete();
			mismatches    <= 0;
			values_due    <= 0;
		end else begin
			// Check the output beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					$display("%0t ns: unexpected output beat, expected none, actual %0d",
						$time, value);
					mismatches <= mismatches + 1;
				end else begin
					exp_val = expected_values.pop_front();
					if (value !== exp_val) begin
						$display("%0t ns: value mismatch, expected %0d, actual %0d",
							$time, exp_val, value);
						mismatches <= mismatches + 1;
					end
				end
			end

			// Mirror config writes
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:        cfg_mode      = cfg_data[0];
					REG_BLOCK_WIDTH: cfg_width     = cfg_data;
					REG_HAS_LEFT:    cfg_has_left  = cfg_data[0];
					REG_HAS_ABOVE:   cfg_has_above = cfg_data[0];
					default: ;
				endcase
			end

			// Predict the value for an accepted input beat
			if (in_valid && !in_stall) begin
				if (cfg_width == 0)
					eff_w = 1;
				else if (cfg_width > MAX_WIDTH)
					eff_w = MAX_WIDTH;
				else
					eff_w = int'(cfg_width);

				if (block_start) begin
					col     = 0;
					top_row = 1'b1;
				end

				if (col == 0)
					nb_left = cfg_has_left ? left_border : '0;
				else
					nb_left = left_pix;

				if (top_row)
					nb_above = cfg_has_above ? top_border : '0;
				else
					nb_above = row_mem[col];

				pred = avg_prediction(nb_left, nb_above);
				if (cfg_mode == MODE_DECODE) begin
					pixel  = sample + pred;
					result = pixel;
				end else begin
					pixel  = sample;
					result = sample - pred;
				end

				row_mem[col] = pixel;
				left_pix     = pixel;

				// Wrap to the next row once the column reaches the width
				if (col + 1 >= eff_w) begin
					col     = 0;
					top_row = 1'b0;
				end else begin
					col = col + 1;
				end

				expected_values.insert(expected_values.size(), result);
			end

			values_due <= expected_values.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the average predictor codec
// Drives directed border and wrap cases, then random phases of config and
// samples with bursty input and patterned output stalls, including one long
// output hold-off over a full-width block; the checker predicts every value.
// ----------------------------------------------------------------------------
module tb_top;
	import apc_pkg::*;

	localparam int RANDOM_ITEMS  = 1450;
	localparam int WIDE_ITEMS    = MAX_WIDTH + 16;
	localparam int WIDE_PHASE    = 6;
	localparam int LONG_HOLD     = 300;
	localparam int PIPE_LATENCY  = 2;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		logic [DATA_W-1:0] smp;
		logic [DATA_W-1:0] lft;
		logic [DATA_W-1:0] top;
		logic              start;
	} beat_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_we      = 1'b0;
	logic [IDX_W-1:0]         cfg_index   = '0;
	logic [BW_W-1:0]          cfg_data    = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] sample      = '0;
	logic signed [DATA_W-1:0] left_border = '0;
	logic signed [DATA_W-1:0] top_border  = '0;
	logic                     block_start = 1'b0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic signed [DATA_W-1:0] value;

	int    fail_count;
	int    values_due;
	beat_t beat_fifo [$];
	int    beats_queued = 0;
	int    beats_taken  = 0;
	logic  in_fire      = 1'b0;
	int    burst_cnt    = 0;
	int    gap_cnt      = 0;
	int    cur_eff      = 8;
	logic  need_start   = 1'b0;
	logic  hold_req     = 1'b0;
	logic  hold_done    = 1'b0;
	int    hold_cnt     = 0;
	int    seg_left     = 0;
	stall_style_t seg_style = STALL_NONE;
	int    cycle_count  = 0;

	average_pixel_predictor_codec u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.left_border (left_border),
		.top_border  (top_border),
		.block_start (block_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value)
	);

	apc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.left_border (left_border),
		.top_border  (top_border),
		.block_start (block_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.mismatches  (fail_count),
		.values_due  (values_due)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Record input handshakes at the rising edge
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			beats_taken <= beats_taken + 1;
	end

	// Present input beats in bursts with random gaps; hold a stalled beat
	always @(negedge clk) begin : drive_in
		beat_t nxt;
		if (!in_valid || in_fire) begin
			if (gap_cnt != 0) begin
				gap_cnt  <= gap_cnt - 1;
				in_valid <= 1'b0;
			end else if (beat_fifo.size() != 0) begin
				nxt = beat_fifo.pop_front();
				sample      <= nxt.smp;
				left_border <= nxt.lft;
				top_border  <= nxt.top;
				block_start <= nxt.start;
				in_valid    <= 1'b1;
				if (burst_cnt <= 1) begin
					burst_cnt <= $urandom_range(1, 32);
					gap_cnt   <= ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_cnt <= burst_cnt - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the output on segments of random style; one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_cnt = hold_cnt + 1;
			if (hold_cnt >= LONG_HOLD)
				hold_done = 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left  = $urandom_range(10, 150);
				seg_style = stall_style_t'($urandom_range(0, 3));
			end else begin
				seg_left = seg_left - 1;
			end
			case (seg_style)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
			3, 4:    return DATA_W'($urandom_range(0, 511)) - DATA_W'(256);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [BW_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return BW_W'($urandom_range(MAX_WIDTH + 1, (1 << BW_W) - 1));
			2, 3:    return BW_W'($urandom_range(9, 40));
			default: return BW_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Wait until every beat is taken and every value has come out
	task automatic wait_idle();
		@(negedge clk);
		while (beats_taken != beats_queued || values_due != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BW_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	// Rewrite all registers; a wider row forces a new block so no unwritten
	// line store entry is ever read
	task automatic apply_config(input logic m, input logic [BW_W-1:0] bw,
			input logic hl, input logic ha);
		int eff;
		wait_idle();
		write_reg(REG_MODE, BW_W'(m));
		write_reg(REG_BLOCK_WIDTH, bw);
		write_reg(REG_HAS_LEFT, BW_W'(hl));
		write_reg(REG_HAS_ABOVE, BW_W'(ha));
		@(negedge clk);
		cfg_we <= 1'b0;
		if (bw == 0)
			eff = 1;
		else if (bw > MAX_WIDTH)
			eff = MAX_WIDTH;
		else
			eff = int'(bw);
		if (eff > cur_eff)
			need_start = 1'b1;
		cur_eff = eff;
	endtask

	task automatic push_beat(input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] l,
			input logic [DATA_W-1:0] t, input logic st);
		beat_t b;
		b.smp   = s;
		b.lft   = l;
		b.top   = t;
		b.start = st | need_start;
		need_start = 1'b0;
		beat_fifo.insert(beat_fifo.size(), b);
		beats_queued = beats_queued + 1;
	endtask

	initial begin : stimulus
		int budget;
		int n;
		int phase;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Saturated and negative neighbor sums with both borders
		apply_config(MODE_ENCODE, BW_W'(3), 1'b1, 1'b1);
		push_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		push_beat(32'h8000_0000, rand_word(), 32'h8000_0000, 1'b0);
		push_beat(32'hffff_ffff, rand_word(), 32'hffff_fffd, 1'b0);
		push_beat(32'h0000_0000, 32'h8000_0000, rand_word(), 1'b0);
		push_beat(32'd5, rand_word(), rand_word(), 1'b0);
		push_beat(32'hffff_fff9, rand_word(), rand_word(), 1'b0);

		// Zero width acts as one column; no borders
		apply_config(MODE_DECODE, BW_W'(0), 1'b0, 1'b0);
		push_beat(32'h7fff_ffff, rand_word(), rand_word(), 1'b1);
		push_beat(32'h8000_0000, rand_word(), rand_word(), 1'b0);
		push_beat(32'd1, rand_word(), rand_word(), 1'b0);

		// Width above the maximum saturates
		apply_config(MODE_DECODE, BW_W'((1 << BW_W) - 1), 1'b1, 1'b0);
		push_beat(rand_word(), rand_word(), rand_word(), 1'b1);
		push_beat(rand_word(), rand_word(), rand_word(), 1'b0);

		// Narrow the width mid-block past the current column
		apply_config(MODE_ENCODE, BW_W'(6), 1'b0, 1'b1);
		for (int i = 0; i < 10; i++)
			push_beat(rand_word(), rand_word(), rand_word(), i == 0);
		apply_config(MODE_ENCODE, BW_W'(2), 1'b0, 1'b1);
		for (int i = 0; i < 4; i++)
			push_beat(rand_word(), rand_word(), rand_word(), 1'b0);

		// Random phases, one of them a full-width block under a long hold-off
		budget = RANDOM_ITEMS;
		phase  = 0;
		while (budget > 0) begin
			if (phase == WIDE_PHASE) begin
				apply_config(rand_bit(), BW_W'(MAX_WIDTH), rand_bit(), rand_bit());
				for (int i = 0; i < WIDE_ITEMS; i++)
					push_beat(rand_word(), rand_word(), rand_word(), i == 0);
				hold_req <= 1'b1;
				n = WIDE_ITEMS;
			end else begin
				n = $urandom_range(8, 40);
				if (n > budget)
					n = budget;
				apply_config(rand_bit(), pick_width(), rand_bit(), rand_bit());
				for (int i = 0; i < n; i++)
					push_beat(rand_word(), rand_word(), rand_word(),
						$urandom_range(0, 49) == 0);
			end
			budget = budget - n;
			phase  = phase + 1;
		end

		wait_idle();
		repeat (4 * PIPE_LATENCY) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
